// File: rtl/core/yrc_pkg.sv
// Shared constants, register map and configuration type of the YUV to RGB converter.
package yrc_pkg;

    // Significant bits of the Y and U samples; V always uses ten bits.
    localparam int SAMPLE_BITS = 16;
    localparam logic [15:0] SAMPLE_MASK = 16'((32'd1 << SAMPLE_BITS) - 1);
    localparam logic [15:0] V_MASK      = 16'h03FF;

    localparam int OFS_W  = 20;  // offsets, unsigned Q16.4
    localparam int RES_W  = 24;  // resolutions, unsigned Q4.20
    localparam int DIFF_W = 21;  // sample minus offset, signed Q.4
    localparam int PRD_W  = 46;  // difference times resolution, signed Q.24
    localparam int MV_W   = 33;  // channel in signed Q.12 millivolts
    localparam int CP_W   = 34;  // coefficient product after the shift
    localparam int BR_W   = 35;  // blue and red before clamping
    localparam int T_W    = 36;  // green numerator
    localparam int G_W    = 37;  // green before clamping
    localparam int CLP_W  = 22;  // clamped colour, 0 to 700 mV in Q.12
    localparam int SCL_W  = 16;  // clamped colour times 255, shifted down by 14

    localparam int NSTG   = 9;   // register stages from input to output

    // Coefficients, unsigned Q.16 values held as positive signed words.
    localparam logic signed [17:0] K_INV_0562 = 18'sd116612;
    localparam logic signed [17:0] K_INV_0710 = 18'sd92304;
    localparam logic signed [17:0] K_0299     = 18'sd19595;
    localparam logic signed [17:0] K_0114     = 18'sd7471;
    localparam logic signed [17:0] K_INV_0587 = 18'sd111646;
    localparam int                 K_SHIFT    = 16;

    // 700 mV in Q.12; 700 << 12 = 175 << 14, so the byte is ((c*255) >> 14) / 175.
    localparam logic [CLP_W-1:0] MV700      = 22'd2867200;
    localparam int               SCL_SHIFT  = 14;
    // floor(n / 175) = (n * 47935) >> 23 for every n up to 44625.
    localparam logic [15:0]      DIV_MUL    = 16'd47935;
    localparam int               DIV_SHIFT  = 23;

    typedef enum logic [2:0] {
        REG_Y_OFFSET = 3'd0,
        REG_U_OFFSET = 3'd1,
        REG_V_OFFSET = 3'd2,
        REG_Y_RES    = 3'd3,
        REG_U_RES    = 3'd4,
        REG_V_RES    = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [OFS_W-1:0] y_offset;
        logic [OFS_W-1:0] u_offset;
        logic [OFS_W-1:0] v_offset;
        logic [RES_W-1:0] y_res;
        logic [RES_W-1:0] u_res;
        logic [RES_W-1:0] v_res;
    } t_cfg;

endpackage

// File: rtl/core/video_yuv_to_rgb_converter_top.sv
// Top level of the YUV to RGB converter: register port and conversion pipeline.
//
// Converts one Y, U, V sample triple per word into a blue, green, red byte triple
// using BT.601 analogue levels: each channel has its offset removed and is scaled
// to millivolts by its resolution register, the colours are formed, clamped to
// 0..700 mV and scaled to 0..255. The pipeline accepts one word every clock while
// the output is not stalled, and each result passes through the nine register
// stages, one per multiplier or adder level. Back-pressure on the output only
// stops the input once every stage holds a word. The tlast flag
// follows its pixel. Offsets and resolutions all reset to zero and are to be
// written while no pixel is in flight.
module video_yuv_to_rgb_converter_top import yrc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // [15:0] y_sample, [31:16] u_sample, [47:32] v_sample
    input  logic        i_s_axis_tlast,   // line_end
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] blue, [15:8] green, [23:16] red
    output logic        o_m_axis_tlast    // line_end_out
);

    t_cfg     r_cfg;
    logic     wr_en;
    t_reg_idx reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_Y_OFFSET: r_cfg.y_offset <= pwdata[OFS_W-1:0];
                REG_U_OFFSET: r_cfg.u_offset <= pwdata[OFS_W-1:0];
                REG_V_OFFSET: r_cfg.v_offset <= pwdata[OFS_W-1:0];
                REG_Y_RES:    r_cfg.y_res    <= pwdata[RES_W-1:0];
                REG_U_RES:    r_cfg.u_res    <= pwdata[RES_W-1:0];
                REG_V_RES:    r_cfg.v_res    <= pwdata[RES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_Y_OFFSET: prdata = {{(32-OFS_W){1'b0}}, r_cfg.y_offset};
            REG_U_OFFSET: prdata = {{(32-OFS_W){1'b0}}, r_cfg.u_offset};
            REG_V_OFFSET: prdata = {{(32-OFS_W){1'b0}}, r_cfg.v_offset};
            REG_Y_RES:    prdata = {{(32-RES_W){1'b0}}, r_cfg.y_res};
            REG_U_RES:    prdata = {{(32-RES_W){1'b0}}, r_cfg.u_res};
            REG_V_RES:    prdata = {{(32-RES_W){1'b0}}, r_cfg.v_res};
            default:      prdata = '0;
        endcase
    end

    yrc_pipe u_pipe (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

// File: rtl/core/yrc_pipe.sv
// Nine-stage conversion pipeline from YUV samples to an RGB byte triple.
module yrc_pipe import yrc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // y_sample, u_sample, v_sample
    input  logic        i_s_axis_tlast,   // line_end
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // blue, green, red
    output logic        o_m_axis_tlast    // line_end_out
);

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] r_last;
    logic [NSTG-1:0] en;

    // Stage 0: offset subtraction
    logic signed [DIFF_W-1:0] r_dy, r_du, r_dv, n_dy, n_du, n_dv;
    // Stage 1: millivolts
    logic signed [MV_W-1:0]   r_y1, r_u1, r_v1, n_y1, n_u1, n_v1;
    // Stage 2: chroma terms
    logic signed [MV_W-1:0]   r_y2;
    logic signed [CP_W-1:0]   r_ub2, r_vr2, n_ub2, n_vr2;
    // Stage 3: blue and red
    logic signed [MV_W-1:0]   r_y3;
    logic signed [BR_W-1:0]   r_b3, r_r3, n_b3, n_r3;
    // Stage 4: luma weights of blue and red
    logic signed [MV_W-1:0]   r_y4;
    logic signed [BR_W-1:0]   r_b4, r_r4;
    logic signed [CP_W-1:0]   r_pr4, r_pb4, n_pr4, n_pb4;
    // Stage 5: green numerator
    logic signed [T_W-1:0]    r_t5, n_t5;
    logic signed [BR_W-1:0]   r_b5, r_r5;
    // Stage 6: green
    logic signed [G_W-1:0]    r_g6, n_g6;
    logic signed [BR_W-1:0]   r_b6, r_r6;
    // Stage 7: clamped and scaled
    logic [SCL_W-1:0]         r_nb7, r_ng7, r_nr7, n_nb7, n_ng7, n_nr7;
    // Stage 8: output bytes
    logic [7:0]               r_blue, r_green, r_red, n_blue, n_green, n_red;

    logic [15:0]              ys, us, vs;
    logic signed [PRD_W-1:0]  prod_y, prod_u, prod_v;
    logic signed [50:0]       prod_ub, prod_vr;
    logic signed [52:0]       prod_pr, prod_pb;
    logic signed [53:0]       prod_g;
    logic [31:0]              q_b, q_g, q_r;

    function automatic logic [SCL_W-1:0] clamp_scale(input logic signed [G_W-1:0] c);
        logic [CLP_W-1:0] cl;
        logic [29:0]      x;
        if (c[G_W-1]) begin
            cl = '0;
        end else if (c > $signed({{(G_W-CLP_W){1'b0}}, MV700})) begin
            cl = MV700;
        end else begin
            cl = c[CLP_W-1:0];
        end
        x = {cl, 8'b0} - {8'b0, cl};
        return x[29:SCL_SHIFT];
    endfunction

    // A stage takes a new word when it is empty or its own word moves on.
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || i_m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_comb begin
        ys = i_s_axis_tdata[15:0]  & SAMPLE_MASK;
        us = i_s_axis_tdata[31:16] & SAMPLE_MASK;
        vs = i_s_axis_tdata[47:32] & V_MASK;
        n_dy = $signed({1'b0, ys, 4'b0}) - $signed({1'b0, i_cfg.y_offset});
        n_du = $signed({1'b0, us, 4'b0}) - $signed({1'b0, i_cfg.u_offset});
        n_dv = $signed({1'b0, vs, 4'b0}) - $signed({1'b0, i_cfg.v_offset});

        // Taking the upper bits of a signed product rounds towards minus infinity.
        prod_y = PRD_W'(r_dy) * PRD_W'($signed({1'b0, i_cfg.y_res}));
        prod_u = PRD_W'(r_du) * PRD_W'($signed({1'b0, i_cfg.u_res}));
        prod_v = PRD_W'(r_dv) * PRD_W'($signed({1'b0, i_cfg.v_res}));
        n_y1 = prod_y[MV_W+11:12];
        n_u1 = prod_u[MV_W+11:12];
        n_v1 = prod_v[MV_W+11:12];

        prod_ub = 51'(r_u1) * 51'(K_INV_0562);
        prod_vr = 51'(r_v1) * 51'(K_INV_0710);
        n_ub2 = prod_ub[CP_W+K_SHIFT-1:K_SHIFT];
        n_vr2 = prod_vr[CP_W+K_SHIFT-1:K_SHIFT];

        n_b3 = BR_W'(r_ub2) + BR_W'(r_y2);
        n_r3 = BR_W'(r_vr2) + BR_W'(r_y2);

        prod_pr = 53'(r_r3) * 53'(K_0299);
        prod_pb = 53'(r_b3) * 53'(K_0114);
        n_pr4 = prod_pr[CP_W+K_SHIFT-1:K_SHIFT];
        n_pb4 = prod_pb[CP_W+K_SHIFT-1:K_SHIFT];

        n_t5 = T_W'(r_y4) - T_W'(r_pr4) - T_W'(r_pb4);

        prod_g = 54'(r_t5) * 54'(K_INV_0587);
        n_g6 = prod_g[G_W+K_SHIFT-1:K_SHIFT];

        n_nb7 = clamp_scale(G_W'(r_b6));
        n_ng7 = clamp_scale(r_g6);
        n_nr7 = clamp_scale(G_W'(r_r6));

        q_b = 32'(r_nb7) * 32'(DIV_MUL);
        q_g = 32'(r_ng7) * 32'(DIV_MUL);
        q_r = 32'(r_nr7) * 32'(DIV_MUL);
        n_blue  = q_b[DIV_SHIFT+7:DIV_SHIFT];
        n_green = q_g[DIV_SHIFT+7:DIV_SHIFT];
        n_red   = q_r[DIV_SHIFT+7:DIV_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_last[0] <= i_s_axis_tlast;
            r_dy <= n_dy;
            r_du <= n_du;
            r_dv <= n_dv;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (en[k]) begin
                r_last[k] <= r_last[k-1];
            end
        end
        if (en[1]) begin
            r_y1 <= n_y1;
            r_u1 <= n_u1;
            r_v1 <= n_v1;
        end
        if (en[2]) begin
            r_y2  <= r_y1;
            r_ub2 <= n_ub2;
            r_vr2 <= n_vr2;
        end
        if (en[3]) begin
            r_y3 <= r_y2;
            r_b3 <= n_b3;
            r_r3 <= n_r3;
        end
        if (en[4]) begin
            r_y4  <= r_y3;
            r_b4  <= r_b3;
            r_r4  <= r_r3;
            r_pr4 <= n_pr4;
            r_pb4 <= n_pb4;
        end
        if (en[5]) begin
            r_t5 <= n_t5;
            r_b5 <= r_b4;
            r_r5 <= r_r4;
        end
        if (en[6]) begin
            r_g6 <= n_g6;
            r_b6 <= r_b5;
            r_r6 <= r_r5;
        end
        if (en[7]) begin
            r_nb7 <= n_nb7;
            r_ng7 <= n_ng7;
            r_nr7 <= n_nr7;
        end
        if (en[8]) begin
            r_blue  <= n_blue;
            r_green <= n_green;
            r_red   <= n_red;
        end
    end

    assign o_s_axis_tready = en[0];
    assign o_m_axis_tvalid = r_vld[NSTG-1];
    assign o_m_axis_tdata  = {r_red, r_green, r_blue};
    assign o_m_axis_tlast  = r_last[NSTG-1];

endmodule

// File: rtl/core/yrc_checker.sv
// Port-level assertions for the YUV to RGB converter, bound to its top level.
module yrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output word valid straight after reset");

    // With no word at the output every stage can move, so the input is ready.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input not ready while the output stage is empty");

    // A stalled output word stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled output word changed or dropped");

endmodule

bind video_yuv_to_rgb_converter_top yrc_checker u_yrc_checker (.*);

// File: tb/video_yuv_to_rgb_converter_top_test.sv
// Self-checking testbench for the YUV to RGB converter: APB register set-up and pixel streams.
module video_yuv_to_rgb_converter_top_test;
    import yrc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Conversion coefficients in unsigned Q.16, and full scale of 700 mV in Q.12.
    localparam longint COEF_U_TO_B  = 116612;
    localparam longint COEF_V_TO_R  = 92304;
    localparam longint COEF_R_LUMA  = 19595;
    localparam longint COEF_B_LUMA  = 7471;
    localparam longint COEF_G_SCALE = 111646;
    localparam longint FULL_SCALE   = longint'(700) << 12;

    // Addresses past the register map; writes there must leave every register alone.
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    localparam int ITEMS_PER_PHASE = 75;

    typedef struct {
        logic [15:0] y;
        logic [15:0] u;
        logic [15:0] v;
        logic        line_end;
    } yuv_word_t;

    typedef struct {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       line_end;
    } rgb_word_t;

    class rgb_pixel_scoreboard;
        rgb_word_t   rgb_expected_q[$];
        int          errors;
        logic [19:0] y_ofs, u_ofs, v_ofs;
        logic [23:0] y_res, u_res, v_res;

        function new();
            errors = 0;
            y_ofs = '0; u_ofs = '0; v_ofs = '0;
            y_res = '0; u_res = '0; v_res = '0;
        endfunction

        function void set_register(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_Y_OFFSET: y_ofs = val[19:0];
                REG_U_OFFSET: u_ofs = val[19:0];
                REG_V_OFFSET: v_ofs = val[19:0];
                REG_Y_RES:    y_res = val[23:0];
                REG_U_RES:    u_res = val[23:0];
                REG_V_RES:    v_res = val[23:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] register_value(logic [2:0] idx);
            case (idx)
                REG_Y_OFFSET: return 32'(y_ofs);
                REG_U_OFFSET: return 32'(u_ofs);
                REG_V_OFFSET: return 32'(v_ofs);
                REG_Y_RES:    return 32'(y_res);
                REG_U_RES:    return 32'(u_res);
                REG_V_RES:    return 32'(v_res);
                default:      return '0;
            endcase
        endfunction

        // Offset-corrected channel in signed Q.12 millivolts, floored.
        function longint channel_mv(logic [15:0] smp, logic [19:0] ofs, logic [23:0] res);
            longint diff;
            diff = longint'({smp, 4'h0}) - longint'(ofs);
            return (diff * longint'(res)) >>> 12;
        endfunction

        function logic [7:0] mv_to_byte(longint c);
            if (c < 0)
                c = 0;
            if (c > FULL_SCALE)
                c = FULL_SCALE;
            return 8'((c * 255) / FULL_SCALE);
        endfunction

        function rgb_word_t convert_pixel(yuv_word_t p);
            logic [15:0] luma_mask;
            longint      y_mv, u_mv, v_mv, b_mv, r_mv, t_mv, g_mv;
            rgb_word_t   px;
            luma_mask = 16'((32'd1 << SAMPLE_BITS) - 1);
            y_mv = channel_mv(p.y & luma_mask, y_ofs, y_res);
            u_mv = channel_mv(p.u & luma_mask, u_ofs, u_res);
            v_mv = channel_mv({6'd0, p.v[9:0]}, v_ofs, v_res);
            b_mv = ((u_mv * COEF_U_TO_B) >>> 16) + y_mv;
            r_mv = ((v_mv * COEF_V_TO_R) >>> 16) + y_mv;
            t_mv = y_mv - ((r_mv * COEF_R_LUMA) >>> 16) - ((b_mv * COEF_B_LUMA) >>> 16);
            g_mv = (t_mv * COEF_G_SCALE) >>> 16;
            px.blue     = mv_to_byte(b_mv);
            px.green    = mv_to_byte(g_mv);
            px.red      = mv_to_byte(r_mv);
            px.line_end = p.line_end;
            return px;
        endfunction

        function void note_yuv(yuv_word_t p);
            rgb_expected_q.push_back(convert_pixel(p));
        endfunction

        function void check_rgb(rgb_word_t got);
            rgb_word_t exp;
            if (rgb_expected_q.size() == 0) begin
                $display("%0t: unexpected pixel b=%0d g=%0d r=%0d last=%0b", $time,
                         got.blue, got.green, got.red, got.line_end);
                errors++;
                return;
            end
            exp = rgb_expected_q.pop_front();
            if (got.blue !== exp.blue || got.green !== exp.green ||
                got.red !== exp.red || got.line_end !== exp.line_end) begin
                $display(
                    "%0t: expected b=%0d g=%0d r=%0d last=%0b, actual b=%0d g=%0d r=%0d last=%0b",
                    $time, exp.blue, exp.green, exp.red, exp.line_end,
                    got.blue, got.green, got.red, got.line_end);
                errors++;
            end
        endfunction

        function int pending();
            return rgb_expected_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata;   // [15:0] y_sample, [31:16] u_sample, [47:32] v_sample
    logic        i_s_axis_tlast;   // line_end
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [23:0] o_m_axis_tdata;   // [7:0] blue, [15:8] green, [23:16] red
    logic        o_m_axis_tlast;   // line_end_out

    rgb_pixel_scoreboard sb;
    bit  src_gap_on;
    bit  sink_stall_on;
    int  line_left;
    int  reg_errors;

    video_yuv_to_rgb_converter_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: handshake inputs change only at rising edges, so the falling edge
    // sees exactly what the next rising edge will act on.
    initial begin
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
                sb.check_rgb('{o_m_axis_tdata[7:0], o_m_axis_tdata[15:8],
                               o_m_axis_tdata[23:16], o_m_axis_tlast});
            @(posedge i_clk);
            i_m_axis_tready <= !(sink_stall_on && $urandom_range(99) < 34);
        end
    end

    // Each transfer returns the bus to idle, with psel and penable low, before the task ends.
    task automatic apb_access(input logic [2:0] idx, input logic wr, input logic [31:0] data,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        forever begin
            @(negedge i_clk);
            if (pready)
                break;
            @(posedge i_clk);
        end
        rdata = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
        logic [31:0] unused;
        apb_access(idx, 1'b1, data, unused);
        sb.set_register(idx, data);
    endtask

    // Writes all six registers, then reads each one back.
    task automatic program_settings(input logic [31:0] setting [6]);
        logic [31:0] rd;
        for (int i = REG_Y_OFFSET; i <= REG_V_RES; i++)
            write_register(3'(i), setting[i]);
        for (int i = REG_Y_OFFSET; i <= REG_V_RES; i++) begin
            apb_access(3'(i), 1'b0, '0, rd);
            if (rd !== sb.register_value(3'(i))) begin
                $display("%0t: register %0d read expected %0h, actual %0h", $time, i,
                         sb.register_value(3'(i)), rd);
                reg_errors++;
            end
        end
    endtask

    task automatic send_pixel(input yuv_word_t p);
        while (src_gap_on && $urandom_range(99) < 34) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {p.v, p.u, p.y};
        i_s_axis_tlast  <= p.line_end;
        forever begin
            @(negedge i_clk);
            if (o_s_axis_tready)
                break;
            @(posedge i_clk);
        end
        sb.note_yuv(p);
        @(posedge i_clk);
    endtask

    // Stops the stream and waits for every pixel in flight to come out.
    task automatic drain_pipeline();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (NSTG + 3) @(posedge i_clk);
    endtask

    function automatic yuv_word_t pixel(logic [15:0] y, logic [15:0] u, logic [15:0] v,
                                        logic line_end);
        yuv_word_t p;
        p.y = y; p.u = u; p.v = v; p.line_end = line_end;
        return p;
    endfunction

    function automatic logic [15:0] video_level();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'd1023;
            default: return 16'($urandom_range(1023));
        endcase
    endfunction

    // Plausible video levels most of the time, raw 16-bit noise otherwise.
    function automatic yuv_word_t random_pixel(bit plausible);
        yuv_word_t p;
        if (plausible) begin
            p.y = video_level();
            p.u = video_level();
            p.v = video_level();
            if ($urandom_range(3) == 0)
                p.v[15:10] = 6'($urandom_range(63));
        end else begin
            p.y = 16'($urandom);
            p.u = 16'($urandom);
            p.v = 16'($urandom);
        end
        if (line_left == 0)
            line_left = $urandom_range(1, 12);
        line_left--;
        p.line_end = (line_left == 0);
        return p;
    endfunction

    function automatic logic [31:0] offset_near(int level);
        return 32'((level << 4) | $urandom_range(15));
    endfunction

    initial begin
        logic [31:0] setting [6];
        sb            = new();
        src_gap_on    = 1'b1;
        sink_stall_on = 1'b1;
        line_left     = 0;
        reg_errors    = 0;
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tlast  <= 1'b0;
        i_m_axis_tready <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers at reset: every resolution is zero, so every channel reads 0 mV.
        send_pixel(pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        send_pixel(pixel(16'h0000, 16'h0000, 16'h0000, 1'b0));
        drain_pipeline();

        write_register(REG_SPARE_A, 32'hFFFF_FFFF);
        write_register(REG_SPARE_B, 32'hFFFF_FFFF);

        // Typical levels: black at 64, chroma centred on 512.
        setting = '{32'd1024, 32'd8192, 32'd8192, 32'd838861, 32'd629146, 32'd629146};
        program_settings(setting);
        send_pixel(pixel(16'd64, 16'd512, 16'd512, 1'b0));     // black
        send_pixel(pixel(16'd940, 16'd512, 16'd512, 1'b0));    // white, just past 700 mV
        send_pixel(pixel(16'd500, 16'd512, 16'd512, 1'b0));    // mid grey
        send_pixel(pixel(16'd0, 16'd512, 16'd512, 1'b0));      // luma below black
        send_pixel(pixel(16'hFFFF, 16'd512, 16'd512, 1'b1));
        send_pixel(pixel(16'd400, 16'd0, 16'd512, 1'b0));      // blue driven negative
        send_pixel(pixel(16'd400, 16'hFFFF, 16'd512, 1'b0));   // blue saturates, green negative
        send_pixel(pixel(16'd400, 16'd512, 16'd0, 1'b0));
        send_pixel(pixel(16'd400, 16'd512, 16'd1023, 1'b0));
        send_pixel(pixel(16'd400, 16'd512, 16'hFC00 | 16'd700, 1'b1)); // V upper bits ignored
        drain_pipeline();

        setting = '{default: 32'hFFFF_FFFF};
        program_settings(setting);
        send_pixel(pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
        send_pixel(pixel(16'h0000, 16'h0000, 16'h0000, 1'b1));
        send_pixel(pixel(16'hFFFF, 16'h0000, 16'h03FF, 1'b0));
        drain_pipeline();

        setting = '{32'd0, 32'd0, 32'd0, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF};
        program_settings(setting);
        send_pixel(pixel(16'hFFFF, 16'hFFFF, 16'h03FF, 1'b1));
        send_pixel(pixel(16'd1, 16'd0, 16'd0, 1'b0));
        send_pixel(pixel(16'd0, 16'd1, 16'd1, 1'b1));
        drain_pipeline();

        for (int ph = 0; ph < 6; ph++) begin
            src_gap_on    = (ph != 1);
            sink_stall_on = (ph != 1);
            case (ph)
                2: foreach (setting[i]) setting[i] = $urandom;
                4: foreach (setting[i]) setting[i] = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
                default: begin
                    setting[REG_Y_OFFSET] = offset_near($urandom_range(128));
                    setting[REG_U_OFFSET] = offset_near($urandom_range(448, 576));
                    setting[REG_V_OFFSET] = offset_near($urandom_range(448, 576));
                    setting[REG_Y_RES]    = $urandom_range(500000, 1100000);
                    setting[REG_U_RES]    = $urandom_range(400000, 900000);
                    setting[REG_V_RES]    = $urandom_range(400000, 900000);
                end
            endcase
            program_settings(setting);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Halfway through one phase the sender holds off until the pipeline is empty.
                if (ph == 3 && n == ITEMS_PER_PHASE / 2)
                    drain_pipeline();
                send_pixel(random_pixel($urandom_range(99) < 80));
            end
            drain_pipeline();
        end

        if (sb.errors == 0 && reg_errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
